// ----- src/mcu_pkg.sv -----
// ----------------------------------------------------------------------------
// mcu_pkg
// Shared types and constants of the macropixel chroma upsampler.
// ----------------------------------------------------------------------------
package mcu_pkg;

    // Default depth of the job queue between front and back end
    localparam int MCU_JOB_DEPTH = 2;

    // Mode register values
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_PAIR   = 2'd2;
    localparam logic [1:0] MODE_TRIPLE = 2'd3;

    typedef enum logic [1:0] {
        CFG_MODE         = 2'd0,
        CFG_WEIGHT_THIS  = 2'd1,
        CFG_WEIGHT_NEXT  = 2'd2,
        CFG_WEIGHT_AFTER = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] weight_this;
        logic [7:0] weight_next;
        logic [7:0] weight_after;
    } t_cfg;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] blue_diff;
        logic [7:0] luma_second;
        logic [7:0] red_diff;
        logic       row_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] pixel_luma;
        logic [7:0] pixel_cb;
        logic [7:0] pixel_cr;
        logic       row_end;
        logic       run_last;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] y0;
        logic [7:0] cb;
        logic [7:0] y1;
        logic [7:0] cr;
    } t_mp;

    // One released macropixel with the chroma of its neighbors
    typedef struct packed {
        t_mp        mp;
        logic [7:0] n1_cb;
        logic [7:0] n1_cr;
        logic [7:0] n2_cb;
        logic [7:0] n2_cr;
        logic       row_end;
        logic       run_last;
        logic [1:0] mode;
    } t_job;

endpackage

// ----- src/mcu_stream_if.sv -----
// ----------------------------------------------------------------------------
// mcu_stream_if
// Valid/ready stream channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface mcu_stream_if #(
    parameter type t_payload = logic [7:0]
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/mcu_job_fifo.sv -----
// ----------------------------------------------------------------------------
// mcu_job_fifo
// Short job queue that decouples the window front end from the blend engine.
// ----------------------------------------------------------------------------
module mcu_job_fifo #(
    parameter int DEPTH = mcu_pkg::MCU_JOB_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  mcu_pkg::t_job i_push_job,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output mcu_pkg::t_job o_pop_job
);
    import mcu_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ----- src/mcu_front.sv -----
// ----------------------------------------------------------------------------
// mcu_front
// Accepts macropixels into a three-entry window, decides how many are
// released, and pushes one job per released macropixel, oldest first.
// ----------------------------------------------------------------------------
module mcu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mcu_pkg::t_cfg i_cfg,
    mcu_stream_if.sink    i_px,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output mcu_pkg::t_job o_job
);
    import mcu_pkg::*;

    t_mp        r_q [3];
    logic [1:0] r_len;
    logic [1:0] r_rem;
    logic       r_last;
    logic [1:0] r_mode;

    t_mp        n_mp;
    logic [1:0] n_mode;
    logic [1:0] n_keep;
    logic [1:0] n_len;
    logic [1:0] n_count;
    logic       accept;
    logic       push;

    assign i_px.ready = (r_rem == '0);
    assign accept     = i_px.valid && i_px.ready;
    assign push       = o_job_valid && i_job_ready;

    always_comb begin
        n_mp.y0 = i_px.data.luma_first;
        n_mp.cb = i_px.data.blue_diff;
        n_mp.y1 = i_px.data.luma_second;
        n_mp.cr = i_px.data.red_diff;
        n_mode  = (i_cfg.mode == MODE_NONE) ? MODE_SINGLE : i_cfg.mode;
        n_keep  = i_px.data.row_last ? 2'd0 : n_mode - 2'd1;
        n_len   = r_len + 2'd1;
        n_count = (n_len > n_keep) ? n_len - n_keep : 2'd0;
    end

    // Neighbors beyond the row end take the macropixel's own chroma
    always_comb begin
        o_job_valid     = (r_rem != '0);
        o_job.mp        = r_q[0];
        o_job.n1_cb     = (r_len > 2'd1) ? r_q[1].cb : r_q[0].cb;
        o_job.n1_cr     = (r_len > 2'd1) ? r_q[1].cr : r_q[0].cr;
        o_job.n2_cb     = (r_len > 2'd2) ? r_q[2].cb : r_q[0].cb;
        o_job.n2_cr     = (r_len > 2'd2) ? r_q[2].cr : r_q[0].cr;
        o_job.row_end   = r_last && (r_len == 2'd1);
        o_job.run_last  = (r_rem == 2'd1);
        o_job.mode      = r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < 3; k++) begin
                if (r_len == 2'(k)) begin
                    r_q[k] <= n_mp;
                end
            end
            r_last <= i_px.data.row_last;
            r_mode <= n_mode;
        end else if (push) begin
            // advance the window by one macropixel
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_rem <= '0;
        end else if (accept) begin
            r_len <= n_len;
            r_rem <= n_count;
        end else if (push) begin
            r_len <= r_len - 2'd1;
            r_rem <= r_rem - 2'd1;
        end
    end

endmodule

// ----- src/mcu_back.sv -----
// ----------------------------------------------------------------------------
// mcu_back
// Blend engine: weighted chroma sum by multiply-accumulate, restoring
// division one quotient bit per cycle, then emits the two output pixels.
// ----------------------------------------------------------------------------
module mcu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mcu_pkg::t_cfg i_cfg,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  mcu_pkg::t_job i_job,
    mcu_stream_if.source  o_px
);
    import mcu_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MAC  = 5'b00010,
        S_DIV  = 5'b00100,
        S_PIX0 = 5'b01000,
        S_PIX1 = 5'b10000
    } t_bstate;

    t_bstate     r_state;
    t_job        r_job;
    logic [9:0]  r_wsum;
    logic [1:0]  r_term;
    logic [2:0]  r_step;
    logic [17:0] r_acc_cb;
    logic [17:0] r_acc_cr;
    logic [17:0] r_dsh;
    logic [7:0]  r_q_cb;
    logic [7:0]  r_q_cr;

    logic [9:0]  n_wsum;
    logic        blend;
    logic [7:0]  w_sel;
    logic [7:0]  c_cb_sel;
    logic [7:0]  c_cr_sel;
    logic [15:0] prod_cb;
    logic [15:0] prod_cr;
    logic        ge_cb;
    logic        ge_cr;

    assign o_job_ready = (r_state == S_IDLE);

    always_comb begin
        if (i_job.mode == MODE_TRIPLE) begin
            n_wsum = 10'(i_cfg.weight_this) + 10'(i_cfg.weight_next)
                   + 10'(i_cfg.weight_after);
        end else begin
            n_wsum = 10'(i_cfg.weight_this) + 10'(i_cfg.weight_next);
        end
        blend = ((i_job.mode == MODE_PAIR) || (i_job.mode == MODE_TRIPLE))
             && (n_wsum != '0);
    end

    always_comb begin
        case (r_term)
            2'd0: begin
                w_sel    = i_cfg.weight_this;
                c_cb_sel = r_job.mp.cb;
                c_cr_sel = r_job.mp.cr;
            end
            2'd1: begin
                w_sel    = i_cfg.weight_next;
                c_cb_sel = r_job.n1_cb;
                c_cr_sel = r_job.n1_cr;
            end
            default: begin
                w_sel    = i_cfg.weight_after;
                c_cb_sel = r_job.n2_cb;
                c_cr_sel = r_job.n2_cr;
            end
        endcase
        prod_cb = 16'(w_sel) * 16'(c_cb_sel);
        prod_cr = 16'(w_sel) * 16'(c_cr_sel);
        ge_cb   = (r_acc_cb >= r_dsh);
        ge_cr   = (r_acc_cr >= r_dsh);
    end

    always_comb begin
        o_px.valid = (r_state == S_PIX0) || (r_state == S_PIX1);
        if (r_state == S_PIX1) begin
            o_px.data.pixel_luma = r_job.mp.y1;
            o_px.data.pixel_cb   = r_q_cb;
            o_px.data.pixel_cr   = r_q_cr;
            o_px.data.row_end    = r_job.row_end;
            o_px.data.run_last   = r_job.run_last;
        end else begin
            o_px.data.pixel_luma = r_job.mp.y0;
            o_px.data.pixel_cb   = r_job.mp.cb;
            o_px.data.pixel_cr   = r_job.mp.cr;
            o_px.data.row_end    = 1'b0;
            o_px.data.run_last   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    r_job    <= i_job;
                    r_wsum   <= n_wsum;
                    r_term   <= '0;
                    r_acc_cb <= '0;
                    r_acc_cr <= '0;
                    r_q_cb   <= i_job.mp.cb;
                    r_q_cr   <= i_job.mp.cr;
                end
            end
            S_MAC: begin
                r_acc_cb <= r_acc_cb + 18'(prod_cb);
                r_acc_cr <= r_acc_cr + 18'(prod_cr);
                r_term   <= r_term + 2'd1;
                r_dsh    <= {1'b0, r_wsum, 7'b0};
                r_step   <= 3'd7;
            end
            S_DIV: begin
                // quotient stays below 256, so eight restoring steps suffice
                r_acc_cb <= ge_cb ? r_acc_cb - r_dsh : r_acc_cb;
                r_acc_cr <= ge_cr ? r_acc_cr - r_dsh : r_acc_cr;
                r_q_cb   <= {r_q_cb[6:0], ge_cb};
                r_q_cr   <= {r_q_cr[6:0], ge_cr};
                r_dsh    <= r_dsh >> 1;
                r_step   <= r_step - 3'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= blend ? S_MAC : S_PIX0;
                    end
                end
                S_MAC: begin
                    if (r_term == r_job.mode - 2'd1) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_step == '0) begin
                        r_state <= S_PIX0;
                    end
                end
                S_PIX0: begin
                    if (o_px.ready) begin
                        r_state <= S_PIX1;
                    end
                end
                S_PIX1: begin
                    if (o_px.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/macropixel_chroma_upsampler_unit.sv -----
// ----------------------------------------------------------------------------
// macropixel_chroma_upsampler_unit
// 4:2:2 to 4:4:4 chroma upsampler with weighted chroma blend.
// ----------------------------------------------------------------------------
// Input channel i_px takes one macropixel (Y0, Cb, Y1, Cr, row_last) per beat;
// output channel o_px gives one pixel per beat, two per released macropixel.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
// A macropixel is held until the neighbors its mode needs have arrived; the
// row's final macropixel flushes everything held, so one input beat releases
// zero to three macropixels (up to six output beats, run_last on the last).
// The front end takes an input beat whenever it has no releases left to queue,
// and queues its releases one by one into a job queue of JOB_DEPTH entries.
// The blend engine sets the rate and takes a job only while idle: in mode 1
// or with a zero weight sum it goes straight to the pixels, in modes 2 and 3
// through one multiply-add per weight, then one quotient bit per cycle of
// the divider. When the receiver stalls, the pixel on o_px holds, the engine
// stops, and the queue and front end fill before i_px drops ready.
// Reset empties the window and queue and sets mode 1 with all weights 1.
// ----------------------------------------------------------------------------
module macropixel_chroma_upsampler_unit #(
    parameter int JOB_DEPTH = mcu_pkg::MCU_JOB_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    mcu_stream_if.sink   i_px,
    mcu_stream_if.source o_px
);
    import mcu_pkg::*;

    t_cfg r_cfg;
    logic push_valid;
    logic push_ready;
    t_job push_job;
    logic pop_valid;
    logic pop_ready;
    t_job pop_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= MODE_SINGLE;
            r_cfg.weight_this  <= 8'd1;
            r_cfg.weight_next  <= 8'd1;
            r_cfg.weight_after <= 8'd1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:         r_cfg.mode         <= i_cfg_data[1:0];
                CFG_WEIGHT_THIS:  r_cfg.weight_this  <= i_cfg_data;
                CFG_WEIGHT_NEXT:  r_cfg.weight_next  <= i_cfg_data;
                CFG_WEIGHT_AFTER: r_cfg.weight_after <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mcu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_px        (i_px),
        .o_job_valid (push_valid),
        .i_job_ready (push_ready),
        .o_job       (push_job)
    );

    mcu_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_job   (push_job),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_job    (pop_job)
    );

    mcu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (pop_valid),
        .o_job_ready (pop_ready),
        .i_job       (pop_job),
        .o_px        (o_px)
    );

endmodule

// ----- tb/sv/tb_macropixel_chroma_upsampler_unit.sv -----
// ----------------------------------------------------------------------------
// tb_macropixel_chroma_upsampler_unit
// Self-checking bench for the 4:2:2 to 4:4:4 chroma upsampler. A queue-fed
// driver sends macropixel beats, and a scoreboard predicts the released pixel
// pairs from its own copy of the window and registers. A monitor compares
// every output beat field by field. Directed rows come first, covering
// extremes, every mode, zero weight sums, rows shorter than the window, and
// register changes with macropixels held. Randomized rows follow under
// changing register settings, most with valid/ready throttling.
// ----------------------------------------------------------------------------
module tb_macropixel_chroma_upsampler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mcu_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 7;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [1:0] cfg_idx;
    logic [7:0] cfg_data;

    mcu_stream_if #(.t_payload(t_in_beat))  px_in ();
    mcu_stream_if #(.t_payload(t_out_beat)) px_out ();

    macropixel_chroma_upsampler_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_px       (px_in),
        .o_px       (px_out)
    );

    // Scoreboard copy of the registers and the macropixel window
    logic [1:0] cfg_mode;
    logic [7:0] cfg_w_this;
    logic [7:0] cfg_w_next;
    logic [7:0] cfg_w_after;
    t_mp        window_old;
    t_mp        window_new;
    int         window_count;

    t_in_beat   mp_queue[$];
    t_out_beat  pixel_fifo[$];
    int         mp_pushed;
    int         mp_taken;
    int         fail_count;
    int         cycle_count;
    int         gap_pct;
    int         stall_pct;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic [7:0] blend_chroma(input logic [1:0] m, input logic [7:0] own,
                                                input logic [7:0] n1, input logic [7:0] n2);
        int unsigned total;
        int unsigned acc;
        total = 0;
        acc   = 0;
        if (m == MODE_PAIR) begin
            total = int'(cfg_w_this) + int'(cfg_w_next);
            acc   = int'(cfg_w_this) * int'(own) + int'(cfg_w_next) * int'(n1);
        end else if (m == MODE_TRIPLE) begin
            total = int'(cfg_w_this) + int'(cfg_w_next) + int'(cfg_w_after);
            acc   = int'(cfg_w_this) * int'(own) + int'(cfg_w_next) * int'(n1)
                  + int'(cfg_w_after) * int'(n2);
        end
        // Single mode and a zero weight sum both keep the own chroma
        if (total == 0)
            return own;
        return 8'(acc / total);
    endfunction

    task automatic predict_pixels(input t_in_beat b);
        t_mp        win[3];
        t_mp        cur;
        t_mp        nb1;
        t_mp        nb2;
        t_out_beat  px;
        logic [1:0] m;
        int         len;
        int         keep;
        int         cnt;
        win[0] = window_old;
        win[1] = window_new;
        win[2] = '0;
        win[window_count] = {b.luma_first, b.blue_diff, b.luma_second, b.red_diff};
        len  = window_count + 1;
        m    = (cfg_mode == MODE_NONE) ? MODE_SINGLE : cfg_mode;
        keep = b.row_last ? 0 : int'(m) - 1;
        cnt  = (len > keep) ? len - keep : 0;
        for (int i = 0; i < cnt; i++) begin
            cur = win[i];
            nb1 = (i + 1 < len) ? win[i + 1] : cur;
            nb2 = (i + 2 < len) ? win[i + 2] : cur;
            px = '{cur.y0, cur.cb, cur.cr, 1'b0, 1'b0};
            pixel_fifo.push_back(px);
            px.pixel_luma = cur.y1;
            px.pixel_cb   = blend_chroma(m, cur.cb, nb1.cb, nb2.cb);
            px.pixel_cr   = blend_chroma(m, cur.cr, nb1.cr, nb2.cr);
            px.row_end    = b.row_last && (i + 1 == len);
            px.run_last   = (i + 1 == cnt);
            pixel_fifo.push_back(px);
        end
        window_count = len - cnt;
        window_old   = '0;
        window_new   = '0;
        if (window_count >= 1)
            window_old = win[cnt];
        if (window_count >= 2)
            window_new = win[cnt + 1];
    endtask

    // Driver: when the channel is free, send a queued beat or a random gap
    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            px_in.valid <= 1'b0;
        end else begin
            if (px_in.valid && px_in.ready) begin
                predict_pixels(px_in.data);
                mp_taken++;
            end
            if (!px_in.valid || px_in.ready) begin
                if (mp_queue.size() > 0 && $urandom_range(99) >= gap_pct) begin
                    px_in.valid <= 1'b1;
                    px_in.data  <= mp_queue.pop_front();
                end else begin
                    px_in.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out_beat got;
        t_out_beat want;
        if (!i_rst_n) begin
            px_out.ready <= 1'b0;
        end else begin
            if (px_out.valid && px_out.ready) begin
                got = px_out.data;
                if (pixel_fifo.size() == 0) begin
                    $error("unexpected pixel beat: luma %0d cb %0d cr %0d",
                           got.pixel_luma, got.pixel_cb, got.pixel_cr);
                    fail_count++;
                end else begin
                    want = pixel_fifo.pop_front();
                    if (got.pixel_luma !== want.pixel_luma) begin
                        $error("pixel_luma: expected %0d, got %0d", want.pixel_luma,
                               got.pixel_luma);
                        fail_count++;
                    end
                    if (got.pixel_cb !== want.pixel_cb) begin
                        $error("pixel_cb: expected %0d, got %0d", want.pixel_cb, got.pixel_cb);
                        fail_count++;
                    end
                    if (got.pixel_cr !== want.pixel_cr) begin
                        $error("pixel_cr: expected %0d, got %0d", want.pixel_cr, got.pixel_cr);
                        fail_count++;
                    end
                    if (got.row_end !== want.row_end) begin
                        $error("row_end: expected %0d, got %0d", want.row_end, got.row_end);
                        fail_count++;
                    end
                    if (got.run_last !== want.run_last) begin
                        $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
                        fail_count++;
                    end
                end
            end
            px_out.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_in_beat make_mp(input logic [7:0] y0, input logic [7:0] cb,
                                         input logic [7:0] y1, input logic [7:0] cr,
                                         input logic last);
        return '{y0, cb, y1, cr, last};
    endfunction

    task automatic send_mp(input t_in_beat b);
        mp_queue.push_back(b);
        mp_pushed++;
    endtask

    task automatic send_row(input int n, input bit close);
        for (int k = 0; k < n; k++)
            send_mp(make_mp(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                            close && (k == n - 1)));
    endtask

    // Hold off until every beat is taken and every pixel is back, then let
    // the engine run dry
    task automatic drain_pixels();
        while (mp_taken != mp_pushed || pixel_fifo.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:         cfg_mode    = val[1:0];
            CFG_WEIGHT_THIS:  cfg_w_this  = val;
            CFG_WEIGHT_NEXT:  cfg_w_next  = val;
            CFG_WEIGHT_AFTER: cfg_w_after = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [1:0] m, input logic [7:0] wt,
                              input logic [7:0] wn, input logic [7:0] wa);
        write_reg(CFG_MODE, {6'd0, m});
        write_reg(CFG_WEIGHT_THIS, wt);
        write_reg(CFG_WEIGHT_NEXT, wn);
        write_reg(CFG_WEIGHT_AFTER, wa);
    endtask

    function automatic logic [7:0] pick_weight();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial begin : stimulus
        logic [1:0] m;
        int         sel;
        int         n;
        int         phase_items;
        px_in.valid  = 1'b0;
        px_in.data   = '0;
        px_out.ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_MODE;
        cfg_data     = '0;
        cfg_mode     = MODE_SINGLE;
        cfg_w_this   = 8'd1;
        cfg_w_next   = 8'd1;
        cfg_w_after  = 8'd1;
        window_old   = '0;
        window_new   = '0;
        window_count = 0;
        mp_pushed    = 0;
        mp_taken     = 0;
        fail_count   = 0;
        cycle_count  = 0;
        gap_pct      = 19;
        stall_pct    = 75;
        i_rst_n      = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: all-zero and all-one beats, one-macropixel row
        send_mp(make_mp(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_mp(make_mp(8'hff, 8'hff, 8'hff, 8'hff, 1'b1));
        send_mp(make_mp(8'h12, 8'hf0, 8'h34, 8'h0f, 1'b1));
        drain_pixels();

        // Pair blend with top weights, then a row too short for the window
        set_config(MODE_PAIR, 8'd255, 8'd255, 8'd1);
        send_mp(make_mp(8'h01, 8'hff, 8'h02, 8'h00, 1'b0));
        send_mp(make_mp(8'h03, 8'h00, 8'h04, 8'hff, 1'b0));
        send_mp(make_mp(8'h05, 8'h7f, 8'h06, 8'h80, 1'b1));
        send_mp(make_mp(8'h07, 8'h55, 8'h08, 8'haa, 1'b1));
        drain_pixels();

        // Zero weight sums fall back to the own chroma
        set_config(MODE_PAIR, 8'd0, 8'd0, 8'd1);
        send_row(2, 1'b1);
        drain_pixels();
        set_config(MODE_TRIPLE, 8'd0, 8'd0, 8'd0);
        send_row(3, 1'b1);
        drain_pixels();

        // Triple blend: short row stands in own chroma, longer row slides
        set_config(MODE_TRIPLE, 8'd255, 8'd1, 8'd255);
        send_row(2, 1'b1);
        send_row(4, 1'b1);
        drain_pixels();

        set_config(MODE_NONE, 8'd9, 8'd200, 8'd3);
        send_row(2, 1'b1);
        drain_pixels();

        // Two held in triple mode, then single mode releases all three at once
        set_config(MODE_TRIPLE, 8'd1, 8'd2, 8'd3);
        send_row(2, 1'b0);
        drain_pixels();
        set_config(MODE_SINGLE, 8'd1, 8'd2, 8'd3);
        send_row(1, 1'b0);
        drain_pixels();

        // Weights change while one macropixel is held
        set_config(MODE_PAIR, 8'd1, 8'd1, 8'd1);
        send_row(1, 1'b0);
        drain_pixels();
        set_config(MODE_PAIR, 8'd3, 8'd200, 8'd1);
        send_row(1, 1'b1);
        drain_pixels();

        for (int p = 0; p < 9; p++) begin
            if (p < 3) begin
                gap_pct   = 19;
                stall_pct = 75;
            end else if (p < 6) begin
                gap_pct   = 75;
                stall_pct = 19;
            end else begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            sel = $urandom_range(9);
            if (sel == 0)
                m = MODE_NONE;
            else if (sel <= 2)
                m = MODE_SINGLE;
            else if (sel <= 5)
                m = MODE_PAIR;
            else
                m = MODE_TRIPLE;
            if ($urandom_range(9) == 0)
                set_config(m, 8'd0, 8'd0, 8'd0);
            else
                set_config(m, pick_weight(), pick_weight(), pick_weight());
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                n = $urandom_range(1, 6);
                phase_items += n;
                // Leave the phase's last row open now and then
                send_row(n, phase_items < PHASE_ITEMS || $urandom_range(4) != 0);
                // Pause the sender once per phase until the pixels are back
                if (phase_items == n)
                    drain_pixels();
            end
            drain_pixels();
        end

        drain_pixels();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
